FILE: rtl/core/rds_pkg.sv
// Shared types, constants and widths for the reaction-diffusion stencil unit.
`timescale 1ns / 1ps

package rds_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS       = 16;
  localparam int DEFAULT_MAX_WIDTH = 256;
  localparam int GW_W              = 9;
  localparam int GH_W              = 16;
  localparam int D_W               = 24;
  localparam int OUT_W             = 40;
  localparam int FRAC_BITS         = 12;
  localparam int CFG_IDX_W         = 2;

  // Datapath widths: a = 1 - 4d - u in units of 2^-12, nsum = neighbour sum
  localparam int A_W   = ((SAMPLE_BITS > 30) ? SAMPLE_BITS : 30) + 3;
  localparam int N_W   = SAMPLE_BITS + 2;
  localparam int P1_W  = A_W + SAMPLE_BITS;
  localparam int P2_W  = D_W + 1 + N_W;
  localparam int ACC_W = ((P1_W > 63) ? P1_W : 63) + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_SQ = 2'd2;

  // Register reset values
  localparam logic [GW_W-1:0] GRID_WIDTH_RST     = 9'd256;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST    = 16'd256;
  localparam logic [D_W-1:0]  INV_SPACING_SQ_RST = 24'd256;

  // Opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
  } rds_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] rate_value;
    logic                    frame_last;
  } rds_out_t;

  // What the front end decided for one accepted item
  typedef struct packed {
    logic                          emit;
    logic                          mid_write;
    logic                          up_on;
    logic                          left_on;
    logic                          right_on;
    logic                          down_on;
    logic                          last;
    logic signed [SAMPLE_BITS-1:0] sample;
  } rds_op_t;

endpackage

FILE: rtl/core/reaction_diffusion_stencil_unit.sv
// Top level of the reaction-diffusion (Fisher-KPP) five-point stencil unit.
`timescale 1ns / 1ps

// Takes grid samples u (Q4.12) in raster order and returns
// f = (1 - 4d - u)*u + d*(up + left + right + down) in Q.12, saturated to 40 bits,
// with the frame's last point marked. A point's result is produced when the
// sample directly below it is accepted, so results run one row behind; after
// the last row, one flush tick per point drains it. Samples and flush ticks
// are taken one per clock while the output is not stalled; each result
// leaves the output register through a five-register pipeline (store
// read, factors, two products, saturated sum, rounded result). The rate is
// set by the two row stores, each a RAM with one write and two read ports
// that every item uses at most once. The stores need no clearing pass after reset.
// Configuration is taken in any cycle but is only to be written while idle.

module reaction_diffusion_stencil_unit #(
  parameter int MAX_WIDTH = rds_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rds_pkg::rds_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rds_pkg::rds_out_t             out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rds_pkg::D_W-1:0]       cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SB    = rds_pkg::SAMPLE_BITS;

  logic                    accept, ready;
  rds_pkg::rds_op_t        op;
  logic [COL_W-1:0]        col, left_col, right_col;
  logic [rds_pkg::D_W-1:0] d;

  logic [SB-1:0]    up_rd_a, up_rd_b, mid_rd_a, mid_rd_b;
  logic             up_we, mid_we;
  logic [COL_W-1:0] up_waddr, mid_waddr;
  logic [SB-1:0]    up_wdata, mid_wdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = !ready;
  assign accept    = in_valid && ready;

  rds_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (in_item),
    .accept    (accept),
    .op        (op),
    .col       (col),
    .left_col  (left_col),
    .right_col (right_col),
    .d         (d)
  );

  rds_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_WIDTH)
  ) u_upper_row (
    .clk     (clk),
    .we      (up_we),
    .waddr   (up_waddr),
    .wdata   (up_wdata),
    .re      (accept),
    .raddr_a (col),
    .raddr_b (left_col),
    .rdata_a (up_rd_a),
    .rdata_b (up_rd_b)
  );

  rds_ram #(
    .WIDTH(SB),
    .DEPTH(MAX_WIDTH)
  ) u_middle_row (
    .clk     (clk),
    .we      (mid_we),
    .waddr   (mid_waddr),
    .wdata   (mid_wdata),
    .re      (accept),
    .raddr_a (col),
    .raddr_b (right_col),
    .rdata_a (mid_rd_a),
    .rdata_b (mid_rd_b)
  );

  rds_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .col       (col),
    .left_col  (left_col),
    .right_col (right_col),
    .d         (d),
    .ready     (ready),
    .up_rd_a   (up_rd_a),
    .up_rd_b   (up_rd_b),
    .mid_rd_a  (mid_rd_a),
    .mid_rd_b  (mid_rd_b),
    .up_we     (up_we),
    .up_waddr  (up_waddr),
    .up_wdata  (up_wdata),
    .mid_we    (mid_we),
    .mid_waddr (mid_waddr),
    .mid_wdata (mid_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/core/rds_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps

module rds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/core/rds_ctrl.sv
// Configuration registers, raster counters and per-item decisions.
`timescale 1ns / 1ps

module rds_ctrl #(
  parameter int MAX_WIDTH = rds_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [rds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rds_pkg::D_W-1:0]          cfg_data,
  input  rds_pkg::rds_in_t                 item,
  input  logic                             accept,
  output rds_pkg::rds_op_t                 op,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output logic [$clog2(MAX_WIDTH)-1:0]     left_col,
  output logic [$clog2(MAX_WIDTH)-1:0]     right_col,
  output logic [rds_pkg::D_W-1:0]          d
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CW_W  = (COL_W + 1 > rds_pkg::GW_W) ? COL_W + 1 : rds_pkg::GW_W;
  localparam int GH_W  = rds_pkg::GH_W;
  localparam logic [CW_W-1:0] MAX_W_C = CW_W'(MAX_WIDTH);

  logic [rds_pkg::GW_W-1:0] grid_width;
  logic [GH_W-1:0]          grid_height;
  logic [rds_pkg::D_W-1:0]  inv_spacing_sq;

  logic [COL_W-1:0] input_column, input_column_next;
  logic [GH_W-1:0]  input_row, input_row_next;
  logic [COL_W-1:0] output_column, output_column_next;
  logic [GH_W-1:0]  output_row, output_row_next;

  logic [CW_W-1:0] w_used;
  logic [GH_W-1:0] h_used;
  logic [CW_W-1:0] ic_inc, oc_inc;
  logic [GH_W:0]   or_inc;
  logic            is_sample, live, emit_down, emit_flush, oc_wrap, ic_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= rds_pkg::GRID_WIDTH_RST;
      grid_height    <= rds_pkg::GRID_HEIGHT_RST;
      inv_spacing_sq <= rds_pkg::INV_SPACING_SQ_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rds_pkg::REG_GRID_WIDTH:     grid_width     <= cfg_data[rds_pkg::GW_W-1:0];
        rds_pkg::REG_GRID_HEIGHT:    grid_height    <= cfg_data[GH_W-1:0];
        rds_pkg::REG_INV_SPACING_SQ: inv_spacing_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  assign d = inv_spacing_sq;

  always_comb begin
    if (grid_width == '0) begin
      w_used = CW_W'(1);
    end else if (CW_W'(grid_width) > MAX_W_C) begin
      w_used = MAX_W_C;
    end else begin
      w_used = CW_W'(grid_width);
    end
    h_used = (grid_height == '0) ? GH_W'(1) : grid_height;
  end

  always_comb begin
    ic_inc     = CW_W'(input_column) + CW_W'(1);
    oc_inc     = CW_W'(output_column) + CW_W'(1);
    or_inc     = {1'b0, output_row} + (GH_W + 1)'(1);
    ic_wrap    = ic_inc >= w_used;
    oc_wrap    = oc_inc >= w_used;
    is_sample  = item.opcode == rds_pkg::OP_SAMPLE;
    live       = input_row < h_used;
    emit_down  = is_sample && live && (input_row != '0);
    emit_flush = !is_sample && !live;

    op.emit      = emit_down || emit_flush;
    op.mid_write = is_sample && live;
    op.up_on     = output_row != '0;
    op.left_on   = output_column != '0;
    op.right_on  = !oc_wrap;
    op.down_on   = emit_down && (or_inc < {1'b0, h_used});
    op.last      = emit_flush && oc_wrap;
    op.sample    = item.sample;

    // row zero only fills the stores
    col       = (is_sample && live && input_row == '0) ? input_column : output_column;
    left_col  = op.left_on ? output_column - COL_W'(1) : output_column;
    right_col = op.right_on ? oc_inc[COL_W-1:0] : output_column;
  end

  always_comb begin
    input_column_next  = input_column;
    input_row_next     = input_row;
    output_column_next = output_column;
    output_row_next    = output_row;
    if (is_sample && live) begin
      if (ic_wrap) begin
        input_column_next = '0;
        input_row_next    = input_row + GH_W'(1);
      end else begin
        input_column_next = input_column + COL_W'(1);
      end
    end
    if (emit_down || emit_flush) begin
      if (oc_wrap) begin
        output_column_next = '0;
        output_row_next    = or_inc[GH_W-1:0];
      end else begin
        output_column_next = output_column + COL_W'(1);
      end
    end
    // frame done: back to the top left corner
    if (emit_flush && oc_wrap) begin
      input_column_next  = '0;
      input_row_next     = '0;
      output_column_next = '0;
      output_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      output_row    <= '0;
    end else if (accept) begin
      input_column  <= input_column_next;
      input_row     <= input_row_next;
      output_column <= output_column_next;
      output_row    <= output_row_next;
    end
  end

endmodule

FILE: rtl/core/rds_datapath.sv
// Stencil pipeline: store access with write forwarding, products, sum, rounding.
`timescale 1ns / 1ps

module rds_datapath #(
  parameter int MAX_WIDTH = rds_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  rds_pkg::rds_op_t                      op,
  input  logic [$clog2(MAX_WIDTH)-1:0]          col,
  input  logic [$clog2(MAX_WIDTH)-1:0]          left_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]          right_col,
  input  logic [rds_pkg::D_W-1:0]               d,
  output logic                                  ready,
  input  logic [rds_pkg::SAMPLE_BITS-1:0]       up_rd_a,
  input  logic [rds_pkg::SAMPLE_BITS-1:0]       up_rd_b,
  input  logic [rds_pkg::SAMPLE_BITS-1:0]       mid_rd_a,
  input  logic [rds_pkg::SAMPLE_BITS-1:0]       mid_rd_b,
  output logic                                  up_we,
  output logic [$clog2(MAX_WIDTH)-1:0]          up_waddr,
  output logic [rds_pkg::SAMPLE_BITS-1:0]       up_wdata,
  output logic                                  mid_we,
  output logic [$clog2(MAX_WIDTH)-1:0]          mid_waddr,
  output logic [rds_pkg::SAMPLE_BITS-1:0]       mid_wdata,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output rds_pkg::rds_out_t                     out_item
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SB    = rds_pkg::SAMPLE_BITS;
  localparam int A_W   = rds_pkg::A_W;
  localparam int N_W   = rds_pkg::N_W;
  localparam int P1_W  = rds_pkg::P1_W;
  localparam int P2_W  = rds_pkg::P2_W;
  localparam int ACC_W = rds_pkg::ACC_W;
  localparam int OUT_W = rds_pkg::OUT_W;
  localparam logic signed [A_W-1:0]   ONE_Q12    = A_W'(1) <<< rds_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(1) <<< 62;
  localparam logic signed [ACC_W-1:0] SAT_LO     = -SAT_HI;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (rds_pkg::FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX    = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -(ACC_W'(1) <<< (OUT_W - 1));

  function automatic logic signed [ACC_W-1:0] clamp62(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // stage 1: accepted item, store data arrives from the RAM read registers
  logic             s1_valid;
  rds_pkg::rds_op_t s1_op;
  logic [COL_W-1:0] s1_col, s1_left, s1_right;

  // last write into each store, for an item read in the same cycle
  logic             up_rec_valid, mid_rec_valid;
  logic [COL_W-1:0] up_rec_addr, mid_rec_addr;
  logic [SB-1:0]    up_rec_data, mid_rec_data;

  logic signed [SB-1:0]  u, right_n, up_n, left_n;
  logic signed [N_W-1:0] nsum;
  logic signed [A_W-1:0] a_val;

  // stage 2: factors
  logic                  s2_valid, s2_last;
  logic signed [A_W-1:0] s2_a;
  logic signed [SB-1:0]  s2_u;
  logic signed [N_W-1:0] s2_nsum;

  // stage 3: products
  logic                   s3_valid, s3_last;
  logic signed [P1_W-1:0] s3_p1, p1_next;
  logic signed [P2_W-1:0] s3_p2, p2_next;

  // stage 4: saturated sum
  logic                    s4_valid, s4_last;
  logic signed [ACC_W-1:0] s4_sum, sum_next;

  logic signed [ACC_W-1:0] rnd, q;
  logic signed [OUT_W-1:0] rate_next;

  logic out_free, s4_free, s3_free, s2_free, s1_go;

  assign out_free = !out_valid || !out_stall;
  assign s4_free  = !s4_valid || out_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign ready    = !s1_valid || s2_free;
  assign s1_go    = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= accept && (op.emit || op.mid_write);
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      s1_op    <= op;
      s1_col   <= col;
      s1_left  <= left_col;
      s1_right <= right_col;
    end
  end

  always_comb begin
    u       = (mid_rec_valid && mid_rec_addr == s1_col)   ? mid_rec_data : mid_rd_a;
    right_n = (mid_rec_valid && mid_rec_addr == s1_right) ? mid_rec_data : mid_rd_b;
    up_n    = (up_rec_valid && up_rec_addr == s1_col)     ? up_rec_data  : up_rd_a;
    left_n  = (up_rec_valid && up_rec_addr == s1_left)    ? up_rec_data  : up_rd_b;

    nsum = (s1_op.up_on    ? N_W'(up_n)         : '0)
         + (s1_op.left_on  ? N_W'(left_n)       : '0)
         + (s1_op.right_on ? N_W'(right_n)      : '0)
         + (s1_op.down_on  ? N_W'(s1_op.sample) : '0);

    a_val = ONE_Q12 - $signed(A_W'({d, 6'b0})) - A_W'(u);
  end

  // the middle row moves up, the new sample takes its place
  assign up_we     = s1_go;
  assign up_waddr  = s1_col;
  assign up_wdata  = u;
  assign mid_we    = s1_go && s1_op.mid_write;
  assign mid_waddr = s1_col;
  assign mid_wdata = s1_op.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_rec_valid  <= 1'b0;
      mid_rec_valid <= 1'b0;
    end else begin
      if (up_we) begin
        up_rec_valid <= 1'b1;
      end
      if (mid_we) begin
        mid_rec_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      up_rec_addr <= up_waddr;
      up_rec_data <= up_wdata;
    end
    if (mid_we) begin
      mid_rec_addr <= mid_waddr;
      mid_rec_data <= mid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid && s1_op.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_last <= s1_op.last;
      s2_a    <= a_val;
      s2_u    <= u;
      s2_nsum <= nsum;
    end
  end

  always_comb begin
    p1_next = s2_a * s2_u;
    p2_next = $signed({1'b0, d}) * s2_nsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_last <= s2_last;
      s3_p1   <= p1_next;
      s3_p2   <= p2_next;
    end
  end

  assign sum_next = clamp62(clamp62(ACC_W'(s3_p1)) + clamp62(ACC_W'(s3_p2) <<< 4));

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_free) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_free) begin
      s4_last <= s3_last;
      s4_sum  <= sum_next;
    end
  end

  // round half up to 2^-12, then clip to the result width
  always_comb begin
    rnd = clamp62(s4_sum + ROUND_HALF);
    q   = rnd >>> rds_pkg::FRAC_BITS;
    if (q > OUT_MAX) begin
      rate_next = OUT_MAX[OUT_W-1:0];
    end else if (q < OUT_MIN) begin
      rate_next = OUT_MIN[OUT_W-1:0];
    end else begin
      rate_next = q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item.rate_value <= rate_next;
      out_item.frame_last <= s4_last;
    end
  end

endmodule
